>>> rtl/bswm_pkg.sv
package bswm_pkg;

   // Request op codes
   localparam logic [1:0] OP_CTRL    = 2'd0;
   localparam logic [1:0] OP_TRIGGER = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   // CSR indexes
   localparam logic [1:0] CSR_AMPLITUDE = 2'd0;
   localparam logic [1:0] CSR_HALF_PER  = 2'd1;
   localparam logic [1:0] CSR_ONE_SHOT  = 2'd2;

   // CSR reset values
   localparam logic [14:0] AMPLITUDE_RST = 15'd2048;
   localparam logic [15:0] HALF_PER_RST  = 16'd1837;
   localparam logic [15:0] ONE_SHOT_RST  = 16'd4410;

   // Phase accumulator step per sample tick
   localparam logic [16:0] PHASE_STEP = 17'd100;

   // Output saturation bound
   localparam logic signed [16:0] SAT_MAX = 17'sd32767;
   localparam logic signed [16:0] SAT_MIN = -17'sd32767;

   // Control byte bits
   localparam int CTRL_UNMUTE_BIT = 0;
   localparam int CTRL_ONE_SHOT_BIT = 6;
   localparam int CTRL_CONT_BIT = 7;

   typedef enum logic [1:0] {
      MODE_OFF        = 2'd0,
      MODE_ONE_SHOT   = 2'd1,
      MODE_CONTINUOUS = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         ctrl_byte;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic [1:0]         beep_mode;
      logic               mute_flag;
   } rsp_type;

   typedef struct packed {
      logic [14:0] amplitude;
      logic [15:0] half_period;
      logic [15:0] one_shot_ticks;
   } cfg_type;

   // Beeper state after the current item, as seen by the mixer
   typedef struct packed {
      logic     tick;
      logic     beep_on;
      logic     wave_high;
      mode_type mode;
      logic     mute;
   } beep_status_type;

endpackage

>>> rtl/bswm_beeper.sv
module bswm_beeper import bswm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_type         item,
   input  cfg_type         cfg,
   output beep_status_type status
);

   mode_type    mode_ff, mode_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [16:0] balance_ff, balance_in;
   logic        wave_ff, wave_in;
   logic        mute_ff, mute_in;

   logic [16:0] bal_sum;
   logic [15:0] rem_dec;

   // Next state for one item
   always_comb begin
      mode_in      = mode_ff;
      remaining_in = remaining_ff;
      balance_in   = balance_ff;
      wave_in      = wave_ff;
      mute_in      = mute_ff;
      bal_sum      = balance_ff + PHASE_STEP;
      rem_dec      = (remaining_ff == 16'd0) ? 16'd0 : remaining_ff - 16'd1;
      case (item.op)
         OP_CTRL: begin
            mute_in = ~item.ctrl_byte[CTRL_UNMUTE_BIT];
            if (item.ctrl_byte[CTRL_CONT_BIT]) begin
               mode_in = MODE_CONTINUOUS;
            end else if (item.ctrl_byte[CTRL_ONE_SHOT_BIT]) begin
               mode_in      = MODE_ONE_SHOT;
               remaining_in = cfg.one_shot_ticks;
            end else begin
               mode_in = MODE_OFF;
            end
         end
         OP_TRIGGER: begin
            mode_in      = MODE_ONE_SHOT;
            remaining_in = cfg.one_shot_ticks;
         end
         OP_TICK: begin
            if (mode_ff != MODE_OFF) begin
               // accumulate and flip once per tick at most
               if (bal_sum >= {1'b0, cfg.half_period}) begin
                  balance_in = bal_sum - {1'b0, cfg.half_period};
                  wave_in    = ~wave_ff;
               end else begin
                  balance_in = bal_sum;
               end
               if (mode_ff == MODE_ONE_SHOT) begin
                  remaining_in = rem_dec;
                  if (rem_dec == 16'd0) begin
                     mode_in = MODE_OFF;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign status.tick      = (item.op == OP_TICK);
   assign status.beep_on   = (item.op == OP_TICK) && (mode_ff != MODE_OFF);
   assign status.wave_high = wave_in;
   assign status.mode      = mode_in;
   assign status.mute      = mute_in;

   // State registers, updated on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         remaining_ff <= 16'd0;
         balance_ff   <= 17'd0;
         wave_ff      <= 1'b0;
         mute_ff      <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         remaining_ff <= remaining_in;
         balance_ff   <= balance_in;
         wave_ff      <= wave_in;
         mute_ff      <= mute_in;
      end
   end

endmodule

>>> rtl/bswm_mix.sv
module bswm_mix import bswm_pkg::*; (
   input  logic               tick,
   input  logic               beep_on,
   input  logic               wave_high,
   input  logic [14:0]        amplitude,
   input  logic signed [15:0] sample_in,
   output logic signed [15:0] sample_out
);

   logic signed [16:0] wave;
   logic signed [16:0] sum;

   // Signed square wave level, zero while the beeper is off
   always_comb begin
      if (!beep_on) begin
         wave = 17'sd0;
      end else if (wave_high) begin
         wave = $signed({2'b00, amplitude});
      end else begin
         wave = -$signed({2'b00, amplitude});
      end
   end

   assign sum = $signed({sample_in[15], sample_in}) + wave;

   // Saturate to the symmetric range; non-tick items carry silence
   always_comb begin
      if (!tick) begin
         sample_out = 16'sd0;
      end else if (sum > SAT_MAX) begin
         sample_out = SAT_MAX[15:0];
      end else if (sum < SAT_MIN) begin
         sample_out = SAT_MIN[15:0];
      end else begin
         sample_out = sum[15:0];
      end
   end

endmodule

>>> rtl/beeper_square_wave_mixer_unit.sv
// Pipeline: a request transfer passes the input register, then the result register,
// before its response is presented; a stall on the response side holds items in place.
// Throughput: one item per cycle unless the response side stalls; the beeper state
// update and the mix sit between the input and the result register in a single pass.
// Reset: synchronous; clears the beeper state and pipeline valids and loads the CSR
// defaults (amplitude 2048, half period 1837, one-shot length 4410).
module beeper_square_wave_mixer_unit import bswm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type         cfg_ff;
   logic            in_valid_ff;
   req_type         in_data_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic            advance;
   beep_status_type status;
   logic signed [15:0] left_mix, right_mix;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amplitude      <= AMPLITUDE_RST;
         cfg_ff.half_period    <= HALF_PER_RST;
         cfg_ff.one_shot_ticks <= ONE_SHOT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_AMPLITUDE: cfg_ff.amplitude      <= csr_wdata[14:0];
            CSR_HALF_PER:  cfg_ff.half_period    <= csr_wdata;
            CSR_ONE_SHOT:  cfg_ff.one_shot_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Item moves from the input register to the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   bswm_beeper u_beeper (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .status (status)
   );

   bswm_mix u_mix_left (
      .tick       (status.tick),
      .beep_on    (status.beep_on),
      .wave_high  (status.wave_high),
      .amplitude  (cfg_ff.amplitude),
      .sample_in  (in_data_ff.left_in),
      .sample_out (left_mix)
   );

   bswm_mix u_mix_right (
      .tick       (status.tick),
      .beep_on    (status.beep_on),
      .wave_high  (status.wave_high),
      .amplitude  (cfg_ff.amplitude),
      .sample_in  (in_data_ff.right_in),
      .sample_out (right_mix)
   );

   always_comb begin
      rsp_data_in.left_out  = left_mix;
      rsp_data_in.right_out = right_mix;
      rsp_data_in.beep_mode = status.mode;
      rsp_data_in.mute_flag = status.mute;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
